[hdl/pnmhdr_pkg.sv]
// Shared types and character constants for the PNM header parser.
`default_nettype none

package pnmhdr_pkg;

   // Parser phases, one per position in the header grammar.
   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_KIND  = 4'd1,
      PH_SKIP0 = 4'd2,
      PH_DIG0  = 4'd3,
      PH_SKIP1 = 4'd4,
      PH_DIG1  = 4'd5,
      PH_SKIP2 = 4'd6,
      PH_DIG2  = 4'd7,
      PH_EOL   = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      KIND_BIT   = 3'd0,
      KIND_GRAY  = 3'd1,
      KIND_RGB   = 3'd2,
      KIND_FGRAY = 3'd3,
      KIND_FRGB  = 3'd4
   } kind_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
   localparam logic [1:0] ST_BAD_KIND  = 2'd2;

   localparam logic [1:0] PT_BIT   = 2'd0;
   localparam logic [1:0] PT_BYTE  = 2'd1;
   localparam logic [1:0] PT_WORD  = 2'd2;
   localparam logic [1:0] PT_FLOAT = 2'd3;

   localparam logic [1:0] CH_ONE   = 2'd1;
   localparam logic [1:0] CH_THREE = 2'd3;

   localparam logic [7:0] CHR_P       = 8'h50;
   localparam logic [7:0] CHR_4       = 8'h34;
   localparam logic [7:0] CHR_5       = 8'h35;
   localparam logic [7:0] CHR_6       = 8'h36;
   localparam logic [7:0] CHR_LOWER_F = 8'h66;
   localparam logic [7:0] CHR_UPPER_F = 8'h46;
   localparam logic [7:0] CHR_HASH    = 8'h23;
   localparam logic [7:0] CHR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHR_ZERO    = 8'h30;
   localparam logic [7:0] CHR_NINE    = 8'h39;
   localparam logic [7:0] CHR_DOT     = 8'h2E;
   localparam logic [7:0] CHR_DASH    = 8'h2D;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [15:0] max_value;
      logic [1:0]  channel_count;
      logic [1:0]  pixel_type;
      logic [15:0] header_length;
      logic        value_overflow;
   } hdr_result_type;

endpackage

`default_nettype wire

[hdl/pnmhdr_core.sv]
// Header parser state and the per-byte state update.
`default_nettype none

module pnmhdr_core #(
   parameter int VALUE_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step,
   input  wire logic [7:0]                 data_byte,
   input  wire logic                       start_req,
   output logic                            emit,
   output pnmhdr_pkg::hdr_result_type      result
);
   import pnmhdr_pkg::*;

   localparam int PROD_BITS = VALUE_BITS + 4;

   phase_type               phase_ff, phase_in;
   logic                    comment_ff, comment_in;
   logic [VALUE_BITS-1:0]   token_ff, token_in;
   logic [VALUE_BITS-1:0]   width_ff, width_in;
   logic [VALUE_BITS-1:0]   height_ff, height_in;
   kind_type                kind_ff, kind_in;
   logic [15:0]             count_ff, count_in;
   logic                    ovf_ff, ovf_in;
   logic                    emit_ok;
   logic [1:0]              err_status;

   logic                    is_digit;
   logic [7:0]              digit_diff;
   logic [PROD_BITS-1:0]    token_ext;
   logic [PROD_BITS-1:0]    prod;
   logic                    prod_sat;

   assign is_digit   = (data_byte >= CHR_ZERO) && (data_byte <= CHR_NINE);
   assign digit_diff = data_byte - CHR_ZERO;
   assign token_ext  = {4'b0000, token_ff};
   // token * 10 + digit as two shifts and adds.
   assign prod       = (token_ext << 3) + (token_ext << 1)
                       + {{(PROD_BITS-4){1'b0}}, digit_diff[3:0]};
   assign prod_sat   = |prod[PROD_BITS-1:VALUE_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         comment_ff <= 1'b0;
         count_ff   <= 16'd0;
         ovf_ff     <= 1'b0;
         kind_ff    <= KIND_BIT;
      end else begin
         phase_ff   <= phase_in;
         comment_ff <= comment_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         kind_ff    <= kind_in;
      end
      token_ff  <= token_in;
      width_ff  <= width_in;
      height_ff <= height_in;
   end

   always_comb begin
      phase_in   = phase_ff;
      comment_in = comment_ff;
      token_in   = token_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      kind_in    = kind_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      emit       = 1'b0;
      emit_ok    = 1'b0;
      err_status = ST_OK;
      if (step) begin
         if (start_req) begin
            // A start word drops whatever header was in progress.
            comment_in = 1'b0;
            token_in   = '0;
            width_in   = '0;
            height_in  = '0;
            kind_in    = KIND_BIT;
            count_in   = 16'd1;
            ovf_in     = 1'b0;
            if (data_byte != CHR_P) begin
               emit       = 1'b1;
               err_status = ST_BAD_MAGIC;
               phase_in   = PH_IDLE;
            end else begin
               phase_in = PH_KIND;
            end
         end else if (phase_ff != PH_IDLE) begin
            if (count_ff == COUNT_MAX) begin
               ovf_in = 1'b1;
            end else begin
               count_in = count_ff + 16'd1;
            end
            unique case (phase_ff)
               PH_KIND: begin
                  phase_in = PH_SKIP0;
                  unique case (data_byte)
                     CHR_4:       kind_in = KIND_BIT;
                     CHR_5:       kind_in = KIND_GRAY;
                     CHR_6:       kind_in = KIND_RGB;
                     CHR_LOWER_F: kind_in = KIND_FGRAY;
                     CHR_UPPER_F: kind_in = KIND_FRGB;
                     default: begin
                        emit       = 1'b1;
                        err_status = ST_BAD_KIND;
                        phase_in   = PH_IDLE;
                     end
                  endcase
               end
               PH_SKIP0, PH_SKIP1, PH_SKIP2: begin
                  if (comment_ff) begin
                     if (data_byte == CHR_NEWLINE) begin
                        comment_in = 1'b0;
                     end
                  end else if (is_digit) begin
                     token_in = VALUE_BITS'(digit_diff[3:0]);
                     if (phase_ff == PH_SKIP0) begin
                        phase_in = PH_DIG0;
                     end else if (phase_ff == PH_SKIP1) begin
                        phase_in = PH_DIG1;
                     end else begin
                        phase_in = PH_DIG2;
                     end
                  end else if (data_byte == CHR_HASH) begin
                     comment_in = 1'b1;
                  end
               end
               PH_DIG0, PH_DIG1, PH_DIG2: begin
                  if (is_digit) begin
                     if (prod_sat) begin
                        token_in = '1;
                        ovf_in   = 1'b1;
                     end else begin
                        token_in = prod[VALUE_BITS-1:0];
                     end
                  end else if ((data_byte == CHR_DOT) || (data_byte == CHR_DASH)) begin
                     token_in = token_ff;
                  end else if (phase_ff == PH_DIG0) begin
                     width_in = token_ff;
                     phase_in = PH_SKIP1;
                  end else if ((phase_ff == PH_DIG1) && (kind_ff != KIND_BIT)) begin
                     height_in = token_ff;
                     phase_in  = PH_SKIP2;
                  end else begin
                     // Last token done: the terminator may already close the line.
                     if (phase_ff == PH_DIG1) begin
                        height_in = token_ff;
                     end
                     if (data_byte == CHR_NEWLINE) begin
                        emit     = 1'b1;
                        emit_ok  = 1'b1;
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_EOL;
                     end
                  end
               end
               PH_EOL: begin
                  if (data_byte == CHR_NEWLINE) begin
                     emit     = 1'b1;
                     emit_ok  = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_comb begin
      result               = '0;
      result.header_length = count_in;
      if (emit_ok) begin
         result.status         = ST_OK;
         result.image_width    = 16'(width_in);
         result.image_height   = 16'(height_in);
         result.value_overflow = ovf_in;
         if ((kind_ff == KIND_RGB) || (kind_ff == KIND_FRGB)) begin
            result.channel_count = CH_THREE;
         end else begin
            result.channel_count = CH_ONE;
         end
         if (kind_ff == KIND_BIT) begin
            result.max_value  = 16'd1;
            result.pixel_type = PT_BIT;
         end else begin
            result.max_value = 16'(token_in);
            if ((kind_ff == KIND_FGRAY) || (kind_ff == KIND_FRGB)) begin
               result.pixel_type = PT_FLOAT;
            end else if (33'(token_in) >= 33'd256) begin
               result.pixel_type = PT_WORD;
            end else begin
               result.pixel_type = PT_BYTE;
            end
         end
      end else begin
         result.status = err_status;
      end
   end

   a_emit_goes_idle: assert property (@(posedge clock) disable iff (reset)
      emit |-> (phase_in == PH_IDLE))
      else $error("parser did not return to idle after a result");

   a_idle_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) && !(step && start_req) |=> (phase_ff == PH_IDLE))
      else $error("parser left idle without a start word");

   a_busy_has_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (count_ff != 16'd0))
      else $error("header length is zero inside a header");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      emit && (result.status != ST_OK) |->
         (result.image_width == 16'd0) && (result.channel_count == 2'd0))
      else $error("error result carries nonzero header fields");

endmodule

`default_nettype wire

[hdl/pnm_header_parser.sv]
// Top level of the PNM header parser: input register, parser core, result register.
//
//   channel | direction | ports                                      | meaning
//   req     | in        | req_valid, req_stall, req_data_byte,       | one file byte per word
//           |           | req_start_req                              |
//   rsp     | out       | rsp_valid, rsp_stall, rsp_status, rsp_*    | one header result per word
//
// Each word is taken into an input register and handled by the parser core, whose
// result goes into the output register: one word per cycle while the result side is
// not stalled.
// Synchronous active-high reset leaves the parser idle, waiting for a start word.
// While a result word is stalled, a word in the input register is held there and req_stall rises.
`default_nettype none

module pnm_header_parser #(
   parameter int VALUE_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_start_req,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_image_width,
   output logic [15:0]      rsp_image_height,
   output logic [15:0]      rsp_max_value,
   output logic [1:0]       rsp_channel_count,
   output logic [1:0]       rsp_pixel_type,
   output logic [15:0]      rsp_header_length,
   output logic             rsp_value_overflow
);
   import pnmhdr_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_start_ff;
   logic           out_valid_ff, out_valid_in;
   hdr_result_type out_ff;
   hdr_result_type core_result;
   logic           core_emit;
   logic           out_free;
   logic           step;
   logic           req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step && core_emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_take) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_start_req;
      end
      if (step && core_emit) begin
         out_ff <= core_result;
      end
   end

   pnmhdr_core #(
      .VALUE_BITS(VALUE_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .start_req (in_start_ff),
      .emit      (core_emit),
      .result    (core_result)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_image_width    = out_ff.image_width;
   assign rsp_image_height   = out_ff.image_height;
   assign rsp_max_value      = out_ff.max_value;
   assign rsp_channel_count  = out_ff.channel_count;
   assign rsp_pixel_type     = out_ff.pixel_type;
   assign rsp_header_length  = out_ff.header_length;
   assign rsp_value_overflow = out_ff.value_overflow;

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      step && core_emit |=> out_valid_ff)
      else $error("result word was not registered");

   a_held_word_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_byte_ff))
      else $error("pending input word lost while output stalled");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the PNM header parser with its own byte-level header predictor.
module tb_top;
   import pnmhdr_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int MAX_REPORTS = 10;
   localparam int TOTAL_WORDS = 1850;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_start_req = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_image_width;
   logic [15:0] rsp_image_height;
   logic [15:0] rsp_max_value;
   logic [1:0]  rsp_channel_count;
   logic [1:0]  rsp_pixel_type;
   logic [15:0] rsp_header_length;
   logic        rsp_value_overflow;

   pnm_header_parser dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_start_req      (req_start_req),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_image_width    (rsp_image_width),
      .rsp_image_height   (rsp_image_height),
      .rsp_max_value      (rsp_max_value),
      .rsp_channel_count  (rsp_channel_count),
      .rsp_pixel_type     (rsp_pixel_type),
      .rsp_header_length  (rsp_header_length),
      .rsp_value_overflow (rsp_value_overflow)
   );

   // Predicted parser state.
   phase_type   prs_phase = PH_IDLE;
   logic        prs_in_comment = 1'b0;
   logic [15:0] prs_token = '0;
   logic [15:0] prs_width = '0;
   logic [15:0] prs_height = '0;
   kind_type    prs_kind = KIND_BIT;
   logic [15:0] prs_length = '0;
   logic        prs_overflow = 1'b0;

   hdr_result_type expected_headers[$];

   bit req_gaps_on = 1'b1;
   bit rsp_gaps_on = 1'b1;
   int hold_request = 0;
   int stall_left = 0;
   int failures = 0;
   int words_sent = 0;
   int words_parsed = 0;
   int headers_good = 0;
   int headers_rejected = 0;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic bit is_digit(input logic [7:0] b);
      return b >= CHR_ZERO && b <= CHR_NINE;
   endfunction

   function automatic hdr_result_type header_done();
      hdr_result_type r;
      r = '0;
      r.status = ST_OK;
      r.image_width = prs_width;
      r.image_height = prs_height;
      r.max_value = (prs_kind == KIND_BIT) ? 16'd1 : prs_token;
      r.channel_count = (prs_kind == KIND_RGB || prs_kind == KIND_FRGB) ? CH_THREE : CH_ONE;
      if (prs_kind == KIND_BIT)
         r.pixel_type = PT_BIT;
      else if (prs_kind >= KIND_FGRAY)
         r.pixel_type = PT_FLOAT;
      else if (r.max_value >= 16'd256)
         r.pixel_type = PT_WORD;
      else
         r.pixel_type = PT_BYTE;
      r.header_length = prs_length;
      r.value_overflow = prs_overflow;
      prs_phase = PH_IDLE;
      return r;
   endfunction

   // Advances the predicted state by one word; returns 1 when a header result is due.
   function automatic bit parse_header_byte(input logic [7:0] b, input logic s,
                                            output hdr_result_type r);
      logic [31:0] v;
      r = '0;
      if (s) begin
         prs_phase = PH_IDLE;
         prs_in_comment = 1'b0;
         prs_token = '0;
         prs_width = '0;
         prs_height = '0;
         prs_kind = KIND_BIT;
         prs_length = 16'd1;
         prs_overflow = 1'b0;
         if (b != CHR_P) begin
            r.status = ST_BAD_MAGIC;
            r.header_length = prs_length;
            return 1'b1;
         end
         prs_phase = PH_KIND;
         return 1'b0;
      end
      if (prs_phase == PH_IDLE)
         return 1'b0;
      if (prs_length == COUNT_MAX)
         prs_overflow = 1'b1;
      else
         prs_length = prs_length + 16'd1;
      case (prs_phase)
         PH_KIND: begin
            case (b)
               CHR_4:       prs_kind = KIND_BIT;
               CHR_5:       prs_kind = KIND_GRAY;
               CHR_6:       prs_kind = KIND_RGB;
               CHR_LOWER_F: prs_kind = KIND_FGRAY;
               CHR_UPPER_F: prs_kind = KIND_FRGB;
               default: begin
                  r.status = ST_BAD_KIND;
                  r.header_length = prs_length;
                  prs_phase = PH_IDLE;
                  return 1'b1;
               end
            endcase
            prs_phase = PH_SKIP0;
         end
         PH_SKIP0, PH_SKIP1, PH_SKIP2: begin
            if (prs_in_comment) begin
               if (b == CHR_NEWLINE)
                  prs_in_comment = 1'b0;
            end else if (is_digit(b)) begin
               prs_token = 16'(b - CHR_ZERO);
               prs_phase = phase_type'(prs_phase + 4'd1);
            end else if (b == CHR_HASH) begin
               prs_in_comment = 1'b1;
            end
         end
         PH_DIG0, PH_DIG1, PH_DIG2: begin
            if (is_digit(b)) begin
               v = 32'(prs_token) * 32'd10 + 32'(b - CHR_ZERO);
               if (v > 32'hFFFF) begin
                  v = 32'hFFFF;
                  prs_overflow = 1'b1;
               end
               prs_token = v[15:0];
            end else if (b != CHR_DOT && b != CHR_DASH) begin
               // The terminator is consumed here and never seen by the skip phases.
               if (prs_phase == PH_DIG0) begin
                  prs_width = prs_token;
                  prs_phase = PH_SKIP1;
               end else if (prs_phase == PH_DIG1 && prs_kind != KIND_BIT) begin
                  prs_height = prs_token;
                  prs_phase = PH_SKIP2;
               end else begin
                  if (prs_phase == PH_DIG1)
                     prs_height = prs_token;
                  if (b == CHR_NEWLINE) begin
                     r = header_done();
                     return 1'b1;
                  end
                  prs_phase = PH_EOL;
               end
            end
         end
         PH_EOL: begin
            if (b == CHR_NEWLINE) begin
               r = header_done();
               return 1'b1;
            end
         end
         default: prs_phase = PH_IDLE;
      endcase
      return 1'b0;
   endfunction

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got)
         note_failure($sformatf("%s expected %0d, actual %0d", field, want, got));
   endtask

   // Header result checker.
   always @(posedge clock) begin
      hdr_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_headers.size() == 0) begin
            note_failure($sformatf("result word with nothing expected, status %0d", rsp_status));
         end else begin
            want = expected_headers.pop_front();
            if (want.status == ST_OK)
               headers_good++;
            else
               headers_rejected++;
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("image_width", 32'(want.image_width), 32'(rsp_image_width));
            check_field("image_height", 32'(want.image_height), 32'(rsp_image_height));
            check_field("max_value", 32'(want.max_value), 32'(rsp_max_value));
            check_field("channel_count", 32'(want.channel_count), 32'(rsp_channel_count));
            check_field("pixel_type", 32'(want.pixel_type), 32'(rsp_pixel_type));
            check_field("header_length", 32'(want.header_length), 32'(rsp_header_length));
            check_field("value_overflow", 32'(want.value_overflow),
                        32'(rsp_value_overflow));
         end
      end
   end

   // Result side stall: a random wait after each taken word (when rsp_gaps_on is set), or a long hold on request.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_left = rsp_gaps_on ? $urandom_range(0, 10) : 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end
      rsp_stall <= (stall_left > 0);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
         $display("pnm_header_parser regression: fail");
         $finish;
      end
   end

   task automatic send_word(input logic [7:0] b, input logic s);
      int gap;
      hdr_result_type r;
      gap = req_gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_start_req <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (s || prs_phase != PH_IDLE)
         words_parsed++;
      if (parse_header_byte(b, s, r))
         expected_headers.push_back(r);
   endtask

   task automatic send_text(input string text, input bit first_is_start);
      for (int i = 0; i < text.len(); i++)
         send_word(text[i], first_is_start && i == 0);
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_headers.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_filler(input bit allow_hash, input bit allow_dot,
                                                input bit allow_newline);
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (is_digit(b) || (!allow_hash && b == CHR_HASH)
             || (!allow_dot && (b == CHR_DOT || b == CHR_DASH))
             || (!allow_newline && b == CHR_NEWLINE));
      return b;
   endfunction

   task automatic test_kinds();
      send_text("P4 3 2\n", 1'b1);
      send_text("P5 640 480 255\n", 1'b1);
      send_text("P5 2 2 256\n", 1'b1);
      send_text("P6 1 1 65535\n", 1'b1);
      send_text("Pf 2 3 1\n", 1'b1);
      send_text("PF 7 8 300\n", 1'b1);
      send_text("P5 0 0 0\n", 1'b1);
      wait_all_results();
   endtask

   task automatic test_rejects();
      send_text("Q5 1 1 1\n", 1'b1);
      send_word(8'h00, 1'b1);
      send_word(8'hFF, 1'b1);
      send_text("P7", 1'b1);
      send_text("P3", 1'b1);
      send_text("P\xff", 1'b1);
      // Words after a rejected header are ignored until the next start.
      send_text("5 1 2 3\n", 1'b0);
      wait_all_results();
   endtask

   task automatic test_syntax();
      send_text("P5\n# size 12 34\n 4 # x\n5 6\n", 1'b1);
      send_text("P5 4#5 6\n", 1'b1);
      send_text("P5 1.2-3 4 5\n", 1'b1);
      send_text("P6 2 2 9 junk#\n", 1'b1);
      send_text("P4 5 6 7\n", 1'b1);
      send_text("xyz 1 2\n", 1'b0);
      send_text("P5 12 ", 1'b1);
      send_text("P4 1 1\n", 1'b1);
      send_text("P6 # in a comment", 1'b1);
      send_text("P6 2 3 4\n", 1'b1);
      wait_all_results();
   endtask

   task automatic test_saturation();
      send_text("P5 99999 70000 123456789\n", 1'b1);
      send_text("P4 65535 65536\n", 1'b1);
      send_text("P6 6553 65530 65535\n", 1'b1);
      wait_all_results();
   endtask

   task automatic test_backpressure();
      logic [7:0] b;
      req_gaps_on = 1'b0;
      hold_request = 150;
      repeat (40) begin
         b = 8'($urandom_range(0, 255));
         if (b == CHR_P)
            b = 8'h00;
         send_word(b, 1'b1);
      end
      wait_all_results();
      req_gaps_on = 1'b1;
   endtask

   task automatic send_random_header();
      logic [7:0] text[$];
      int k;
      int len;
      text.push_back($urandom_range(0, 19) == 0 ? 8'($urandom_range(0, 255)) : CHR_P);
      k = $urandom_range(0, 10);
      case (k)
         0, 1:    text.push_back(CHR_4);
         2, 3:    text.push_back(CHR_5);
         4, 5:    text.push_back(CHR_6);
         6, 7:    text.push_back(CHR_LOWER_F);
         8, 9:    text.push_back(CHR_UPPER_F);
         default: text.push_back(8'($urandom_range(0, 255)));
      endcase
      for (int t = 0; t < 3; t++) begin
         repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 5))
               0:       text.push_back(8'h20);
               1:       text.push_back(CHR_NEWLINE);
               2:       text.push_back(8'h09);
               3: begin
                  text.push_back(CHR_HASH);
                  repeat ($urandom_range(0, 6))
                     text.push_back(random_filler(1'b1, 1'b1, 1'b0));
                  text.push_back(CHR_NEWLINE);
               end
               default: text.push_back(random_filler(1'b0, 1'b1, 1'b1));
            endcase
         end
         if (t != 0 || $urandom_range(0, 2) != 0)
            text.push_back(8'h20);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(1, 5);
         repeat (len) begin
            if ($urandom_range(0, 11) == 0)
               text.push_back($urandom_range(0, 1) ? CHR_DOT : CHR_DASH);
            text.push_back(8'(CHR_ZERO + $urandom_range(0, 9)));
         end
         case ($urandom_range(0, 4))
            0:       text.push_back(CHR_NEWLINE);
            1:       text.push_back(CHR_HASH);
            2:       text.push_back(random_filler(1'b1, 1'b0, 1'b0));
            default: text.push_back(8'h20);
         endcase
      end
      // Junk up to the closing newline; harmless when the header already ended.
      repeat ($urandom_range(0, 3)) text.push_back(random_filler(1'b1, 1'b1, 1'b0));
      text.push_back(CHR_NEWLINE);
      // Some headers are cut short and restarted by the next start word.
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, text.size()) : text.size();
      for (int i = 0; i < len; i++)
         send_word(text[i], i == 0);
   endtask

   task automatic test_random_streams();
      while (words_sent < TOTAL_WORDS) begin
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8))
               send_word(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
         end else begin
            send_random_header();
         end
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      wait_all_results();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_kinds();
      test_rejects();
      test_syntax();
      test_saturation();
      test_backpressure();
      test_random_streams();
      repeat (12) @(posedge clock);
      if (expected_headers.size() != 0)
         note_failure($sformatf("%0d expected results never arrived", expected_headers.size()));
      $display("covered %0d input words (%0d parsed) and %0d header results",
               words_sent, words_parsed, headers_good + headers_rejected);
      $display("(%0d accepted headers, %0d rejected), %0d failures",
               headers_good, headers_rejected, failures);
      if (failures == 0)
         $display("pnm_header_parser regression: pass");
      else
         $display("pnm_header_parser regression: fail");
      $finish;
   end

endmodule
